>>> design/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants of the spring distance constraint unit
// Holds fixed widths, the item record that rides along the cell chains and
// the output saturation helper.
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int CoordBits   = 32;
	localparam int DiffBits    = CoordBits + 1;          // |delta| magnitude
	localparam int SqBits      = 2 * DiffBits;           // squared length, 66
	localparam int RootBits    = DiffBits;               // floor sqrt, 33
	localparam int RestBits    = 31;
	localparam int StretchBits = 18;
	localparam int NumBits     = SqBits + 1;             // ad * m + len, 67
	localparam int DivBits     = RootBits + 1;           // 2 * len, 34
	localparam int SumBits     = CoordBits + 3;          // coord + correction

	localparam logic [StretchBits-1:0] StretchReset = 18'd72090;
	localparam logic [SqBits-1:0]      MinSqLen     = 66'd43;

	// record carried alongside the arithmetic through every cell
	typedef struct packed {
		logic [2:0][CoordBits-1:0] f;
		logic [2:0][CoordBits-1:0] s;
		logic                      p1;
		logic                      p2;
		logic                      skip;
		logic [2:0]                neg;
		logic [2:0][DiffBits-1:0]  ad;
		logic [RestBits-1:0]       rest;
		logic [RootBits-1:0]       cap;
	} sdc_item_t;

	// clamp a wide signed sum to the signed coordinate range
	function automatic logic [CoordBits-1:0] sat_coord(input logic [SumBits-1:0] v);
		logic [SumBits-1:0] hi;
		logic [SumBits-1:0] lo;
		hi = {{(SumBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}};
		lo = ~hi;
		if (!v[SumBits-1] && (v > hi)) begin
			return hi[CoordBits-1:0];
		end else if (v[SumBits-1] && (v < lo)) begin
			return lo[CoordBits-1:0];
		end else begin
			return v[CoordBits-1:0];
		end
	endfunction

endpackage

>>> design/sdc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sdc_sqrt_cell: one digit step of the integer square root chain
// Brings down two radicand bits, tries the next root bit and hands the
// partial root, remainder and item record to the next cell.
// ----------------------------------------------------------------------------
module sdc_sqrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [sdc_pkg::SqBits-1:0] in_rad,
	input  logic [sdc_pkg::DivBits-1:0] in_rem,
	input  logic [sdc_pkg::RootBits-1:0] in_root,
	input  sdc_pkg::sdc_item_t         in_item,
	output logic                       out_v,
	output logic [sdc_pkg::SqBits-1:0] out_rad,
	output logic [sdc_pkg::DivBits-1:0] out_rem,
	output logic [sdc_pkg::RootBits-1:0] out_root,
	output sdc_pkg::sdc_item_t         out_item
);
	import sdc_pkg::*;

	logic [DivBits+1:0] rem_n;
	logic [DivBits+1:0] trial;
	logic               take;
	logic               v_q;
	logic [SqBits-1:0]  rad_q;
	logic [DivBits-1:0] rem_q;
	logic [RootBits-1:0] root_q;
	sdc_item_t          item_q;

	// trial subtract of (4*root + 1)
	always_comb begin
		rem_n = {in_rem, in_rad[SqBits-1 -: 2]};
		trial = {1'b0, in_root, 2'b01};
		take  = (rem_n >= trial);
	end

	// hold valid under stall, clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	// advance the partial result
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {in_rad[SqBits-3:0], 2'b00};
			rem_q  <= take ? DivBits'(rem_n - trial) : DivBits'(rem_n);
			root_q <= {in_root[RootBits-2:0], take};
			item_q <= in_item;
		end
	end

	assign out_v    = v_q;
	assign out_rad  = rad_q;
	assign out_rem  = rem_q;
	assign out_root = root_q;
	assign out_item = item_q;

endmodule

>>> design/sdc_div_cell.sv
// ----------------------------------------------------------------------------
// sdc_div_cell: one quotient bit of the three-lane correction divider
// Each lane shifts in one dividend bit, compares against 2*length and hands
// remainder, quotient and item record to the next cell.
// ----------------------------------------------------------------------------
module sdc_div_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_v,
	input  logic [sdc_pkg::DivBits-1:0]       in_d,
	input  logic                              in_shrink,
	input  logic [2:0][sdc_pkg::RootBits-1:0] in_lo,
	input  logic [2:0][sdc_pkg::DivBits-1:0]  in_rem,
	input  logic [2:0][sdc_pkg::RootBits-1:0] in_q,
	input  sdc_pkg::sdc_item_t                in_item,
	output logic                              out_v,
	output logic [sdc_pkg::DivBits-1:0]       out_d,
	output logic                              out_shrink,
	output logic [2:0][sdc_pkg::RootBits-1:0] out_lo,
	output logic [2:0][sdc_pkg::DivBits-1:0]  out_rem,
	output logic [2:0][sdc_pkg::RootBits-1:0] out_q,
	output sdc_pkg::sdc_item_t                out_item
);
	import sdc_pkg::*;

	logic [2:0][DivBits:0]    rem_n;
	logic [2:0]               take;
	logic                     v_q;
	logic [DivBits-1:0]       d_q;
	logic                     shrink_q;
	logic [2:0][RootBits-1:0] lo_q;
	logic [2:0][DivBits-1:0]  rem_q;
	logic [2:0][RootBits-1:0] q_q;
	sdc_item_t                item_q;

	// restoring compare per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_n[i] = {in_rem[i], in_lo[i][RootBits-1]};
			take[i]  = (rem_n[i] >= {1'b0, in_d});
		end
	end

	// hold valid under stall, clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	// advance lanes
	always_ff @(posedge clk) begin
		if (en) begin
			d_q      <= in_d;
			shrink_q <= in_shrink;
			item_q   <= in_item;
			for (int i = 0; i < 3; i++) begin
				lo_q[i]  <= {in_lo[i][RootBits-2:0], 1'b0};
				rem_q[i] <= take[i] ? DivBits'(rem_n[i] - {1'b0, in_d})
				                    : DivBits'(rem_n[i]);
				q_q[i]   <= {in_q[i][RootBits-2:0], take[i]};
			end
		end
	end

	assign out_v      = v_q;
	assign out_d      = d_q;
	assign out_shrink = shrink_q;
	assign out_lo     = lo_q;
	assign out_rem    = rem_q;
	assign out_q      = q_q;
	assign out_item   = item_q;

endmodule

>>> design/spring_distance_constraint_unit.sv
// ----------------------------------------------------------------------------
// spring_distance_constraint_unit: distance constraint projection, one spring
// Forms delta and its squared length, takes the root in a chain of digit
// cells, divides the three corrections in a chain of quotient cells and
// applies them with saturation.
//
//   channel      signals                               direction
//   in           in_valid / in_stall, first_*, second_*, pins, rest  in
//   out          out_valid / out_stall, new_*, skipped              out
//   config       max_stretch_we / max_stretch_wdata    in
//
// One transaction per cycle while in_stall is low. Results pass stages 1-3,
// the 33-cell root chain, stages 4-5, the 33-cell divider chain and stage 6.
// Reset clears all valid flags and loads max_stretch with 1.1.
// A two-entry output stage (output register plus skid) lets the chain keep
// advancing while one result waits; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module spring_distance_constraint_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 max_stretch_we,
	input  logic [sdc_pkg::StretchBits-1:0]      max_stretch_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_z,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_z,
	input  logic                                 first_pinned,
	input  logic                                 second_pinned,
	input  logic [sdc_pkg::RestBits-1:0]         rest_length,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sdc_pkg::CoordBits-1:0] new_first_x,
	output logic signed [sdc_pkg::CoordBits-1:0] new_first_y,
	output logic signed [sdc_pkg::CoordBits-1:0] new_first_z,
	output logic signed [sdc_pkg::CoordBits-1:0] new_second_x,
	output logic signed [sdc_pkg::CoordBits-1:0] new_second_y,
	output logic signed [sdc_pkg::CoordBits-1:0] new_second_z,
	output logic                                 skipped
);
	import sdc_pkg::*;

	localparam int Steps = RootBits;

	typedef struct packed {
		logic [2:0][CoordBits-1:0] f;
		logic [2:0][CoordBits-1:0] s;
		logic                      skip;
	} sdc_res_t;

	logic [StretchBits-1:0] max_stretch_q;
	logic                   en;
	logic                   in_acc;

	// front stages
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	sdc_item_t                it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [2:0][SqBits-1:0]   sqt_s2;
	logic [SqBits-1:0]        sq_s3;
	logic [RootBits-1:0]      len_s4, m_s4;
	logic                     shrink_s4;
	logic [DivBits-1:0]       d_s5;
	logic                     shrink_s5;
	logic [2:0][NumBits-1:0]  num_s5;
	sdc_res_t                 res_s6;

	// root chain wires
	logic                sq_v    [0:Steps];
	logic [SqBits-1:0]   sq_rad  [0:Steps];
	logic [DivBits-1:0]  sq_rem  [0:Steps];
	logic [RootBits-1:0] sq_root [0:Steps];
	sdc_item_t           sq_it   [0:Steps];

	// divider chain wires
	logic                     dv_v      [0:Steps];
	logic [DivBits-1:0]       dv_d      [0:Steps];
	logic                     dv_shrink [0:Steps];
	logic [2:0][RootBits-1:0] dv_lo     [0:Steps];
	logic [2:0][DivBits-1:0]  dv_rem    [0:Steps];
	logic [2:0][RootBits-1:0] dv_q      [0:Steps];
	sdc_item_t                dv_it     [0:Steps];

	// output stage
	logic     out_v_q, skid_v_q;
	sdc_res_t out_q, skid_q;
	logic     take_out;
	logic     pipe_out;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stretch_q <= StretchReset;
		end else if (max_stretch_we) begin
			max_stretch_q <= max_stretch_wdata;
		end
	end

	// valid flags of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v[Steps];
			v_s5 <= v_s4;
			v_s6 <= dv_v[Steps];
		end
	end

	// stage 1: delta, magnitude and sign
	always_ff @(posedge clk) begin
		logic [2:0][CoordBits-1:0] fv;
		logic [2:0][CoordBits-1:0] sv;
		logic [DiffBits-1:0]       dl;
		if (en) begin
			fv = {first_z, first_y, first_x};
			sv = {second_z, second_y, second_x};
			for (int i = 0; i < 3; i++) begin
				dl = {sv[i][CoordBits-1], sv[i]} - {fv[i][CoordBits-1], fv[i]};
				it_s1.neg[i] <= dl[DiffBits-1];
				it_s1.ad[i]  <= dl[DiffBits-1] ? (~dl + 1'b1) : dl;
			end
			it_s1.f    <= fv;
			it_s1.s    <= sv;
			it_s1.p1   <= first_pinned;
			it_s1.p2   <= second_pinned;
			it_s1.rest <= rest_length;
			it_s1.skip <= 1'b0;
			it_s1.cap  <= '0;
		end
	end

	// stage 2: squares of the three components
	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			for (int i = 0; i < 3; i++) begin
				sqt_s2[i] <= it_s1.ad[i] * it_s1.ad[i];
			end
		end
	end

	// stage 3: squared length, skip decision, stretch cap
	always_ff @(posedge clk) begin
		logic [SqBits-1:0]               sum;
		logic [RestBits+StretchBits-1:0] capw;
		sdc_item_t                       nx;
		if (en) begin
			sum     = sqt_s2[0] + sqt_s2[1] + sqt_s2[2];
			capw    = it_s2.rest * max_stretch_q;
			nx      = it_s2;
			nx.skip = (it_s2.p1 && it_s2.p2) || (sum < MinSqLen);
			nx.cap  = RootBits'(capw >> 16);
			sq_s3 <= sum;
			it_s3 <= nx;
		end
	end

	// root chain
	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = sq_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_it[0]   = it_s3;

	for (genvar k = 0; k < Steps; k++) begin : g_sqrt
		sdc_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (sq_v[k]),
			.in_rad   (sq_rad[k]),
			.in_rem   (sq_rem[k]),
			.in_root  (sq_root[k]),
			.in_item  (sq_it[k]),
			.out_v    (sq_v[k+1]),
			.out_rad  (sq_rad[k+1]),
			.out_rem  (sq_rem[k+1]),
			.out_root (sq_root[k+1]),
			.out_item (sq_it[k+1])
		);
	end

	// stage 4: target length and correction magnitude
	always_ff @(posedge clk) begin
		logic [RootBits-1:0] len;
		logic [RootBits-1:0] tgt;
		if (en) begin
			len = sq_root[Steps];
			tgt = (len > sq_it[Steps].cap) ? sq_it[Steps].cap
			                               : RootBits'(sq_it[Steps].rest);
			len_s4    <= len;
			shrink_s4 <= (len >= tgt);
			m_s4      <= (len >= tgt) ? (len - tgt) : (tgt - len);
			it_s4     <= sq_it[Steps];
		end
	end

	// stage 5: dividends |delta| * m + len and divisor 2 * len
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= NumBits'(it_s4.ad[i]) * NumBits'(m_s4) + NumBits'(len_s4);
			end
			d_s5      <= {len_s4, 1'b0};
			shrink_s5 <= shrink_s4;
			it_s5     <= it_s4;
		end
	end

	// divider chain: upper dividend bits seed the remainder
	assign dv_v[0]      = v_s5;
	assign dv_d[0]      = d_s5;
	assign dv_shrink[0] = shrink_s5;
	assign dv_it[0]     = it_s5;
	assign dv_q[0]      = '0;
	for (genvar i = 0; i < 3; i++) begin : g_seed
		assign dv_rem[0][i] = num_s5[i][NumBits-1 -: DivBits];
		assign dv_lo[0][i]  = num_s5[i][RootBits-1:0];
	end

	for (genvar k = 0; k < Steps; k++) begin : g_div
		sdc_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in_v       (dv_v[k]),
			.in_d       (dv_d[k]),
			.in_shrink  (dv_shrink[k]),
			.in_lo      (dv_lo[k]),
			.in_rem     (dv_rem[k]),
			.in_q       (dv_q[k]),
			.in_item    (dv_it[k]),
			.out_v      (dv_v[k+1]),
			.out_d      (dv_d[k+1]),
			.out_shrink (dv_shrink[k+1]),
			.out_lo     (dv_lo[k+1]),
			.out_rem    (dv_rem[k+1]),
			.out_q      (dv_q[k+1]),
			.out_item   (dv_it[k+1])
		);
	end

	// stage 6: apply corrections and saturate
	always_ff @(posedge clk) begin
		sdc_item_t          it;
		logic [SumBits-1:0] c;
		logic [SumBits-1:0] fw;
		logic [SumBits-1:0] sw;
		if (en) begin
			it = dv_it[Steps];
			res_s6.skip <= it.skip;
			for (int i = 0; i < 3; i++) begin
				c  = {{(SumBits-RootBits){1'b0}}, dv_q[Steps][i]};
				if (it.neg[i] == dv_shrink[Steps]) begin
					c = ~c + 1'b1;
				end
				fw = {{(SumBits-CoordBits){it.f[i][CoordBits-1]}}, it.f[i]};
				sw = {{(SumBits-CoordBits){it.s[i][CoordBits-1]}}, it.s[i]};
				res_s6.f[i] <= (it.skip || it.p1) ? it.f[i] : sat_coord(fw + c);
				res_s6.s[i] <= (it.skip || it.p2) ? it.s[i] : sat_coord(sw - c);
			end
		end
	end

	// output register with skid entry
	assign take_out = out_v_q && !out_stall;
	assign pipe_out = en && v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take_out) begin
			out_v_q  <= skid_v_q || pipe_out;
			skid_v_q <= 1'b0;
		end else if (pipe_out) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take_out) begin
			out_q <= skid_v_q ? skid_q : res_s6;
		end else if (pipe_out) begin
			skid_q <= res_s6;
		end
	end

	assign out_valid    = out_v_q;
	assign new_first_x  = out_q.f[0];
	assign new_first_y  = out_q.f[1];
	assign new_first_z  = out_q.f[2];
	assign new_second_x = out_q.s[0];
	assign new_second_y = out_q.s[1];
	assign new_second_z = out_q.s[2];
	assign skipped      = out_q.skip;

	// skid entry only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output valid");

	// a finished result always lands in the output stage
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_out |=> out_v_q)
		else $error("result from chain dropped");

	// both endpoints pinned always yields a skipped item
	a_pinned_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && it_s4.p1 && it_s4.p2) |-> it_s4.skip)
		else $error("both-pinned spring not skipped");

	// input is taken only while the chain advances
	a_accept_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (v_s1 && !$past(skid_v_q)))
		else $error("input accepted during hold");

endmodule

>>> bench/spring_projection_checker.sv
// ----------------------------------------------------------------------------
// spring_projection_checker: result predictor and scoreboard
// Watches the input, output and configuration ports of the spring distance
// constraint unit. Computes the projected positions for every accepted
// transaction and compares each returned transaction in order.
// ----------------------------------------------------------------------------
module spring_projection_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 max_stretch_we,
	input  logic [sdc_pkg::StretchBits-1:0]      max_stretch_wdata,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] first_z,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] second_z,
	input  logic                                 first_pinned,
	input  logic                                 second_pinned,
	input  logic [sdc_pkg::RestBits-1:0]         rest_length,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_first_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_first_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_first_z,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_second_x,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_second_y,
	input  logic signed [sdc_pkg::CoordBits-1:0] new_second_z,
	input  logic                                 skipped,
	output int                                   mismatches,
	output int                                   pending
);
	import sdc_pkg::*;

	typedef struct packed {
		logic [2:0][CoordBits-1:0] first;
		logic [2:0][CoordBits-1:0] second;
		logic                      skip;
	} positions_t;

	logic [StretchBits-1:0] stretch_cap;
	positions_t             expected_positions[$];

	// clamp to the signed coordinate range
	function automatic logic [CoordBits-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[CoordBits-1:0];
	endfunction

	// project one spring onto its distance constraint
	function automatic positions_t project_spring(
		input logic [2:0][CoordBits-1:0] pf,
		input logic [2:0][CoordBits-1:0] ps,
		input logic pin1, input logic pin2,
		input logic [RestBits-1:0] rest,
		input logic [StretchBits-1:0] stretch);
		positions_t   r;
		longint       f[3], s[3], d[3], c;
		logic [127:0] ad[3], sq, len, cand, cap, target, m, num, mag;
		bit           shrink;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			f[i] = longint'($signed(pf[i]));
			s[i] = longint'($signed(ps[i]));
			d[i] = s[i] - f[i];
			ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
			sq = sq + ad[i] * ad[i];
		end
		r.skip = (pin1 && pin2) || (sq < 128'd43);
		for (int i = 0; i < 3; i++) begin
			r.first[i] = pf[i];
			r.second[i] = ps[i];
		end
		if (r.skip) begin
			return r;
		end
		// floor square root, bit by bit
		len = '0;
		for (int b = 52; b >= 0; b--) begin
			cand = len | (128'd1 << b);
			if (cand * cand <= sq) begin
				len = cand;
			end
		end
		cap = (128'(rest) * 128'(stretch)) >> 16;
		target = (len > cap) ? cap : 128'(rest);
		shrink = len >= target;
		m = shrink ? len - target : target - len;
		for (int i = 0; i < 3; i++) begin
			num = ad[i] * m + len;
			mag = num / (len << 1);
			mag = {64'd0, mag[63:0]};
			if (mag > (128'd1 << 60)) begin
				mag = 128'd1 << 60;
			end
			c = longint'(mag[63:0]);
			if ((d[i] < 0) == shrink) begin
				c = -c;
			end
			r.first[i] = pin1 ? pf[i] : clamp_coord(f[i] + c);
			r.second[i] = pin2 ? ps[i] : clamp_coord(s[i] - c);
		end
		return r;
	endfunction

	// track the stretch register, predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		positions_t exp_p, got;
		if (!arst_n) begin
			stretch_cap <= StretchReset;
			expected_positions.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_positions.insert(expected_positions.size(), project_spring(
					{first_z, first_y, first_x}, {second_z, second_y, second_x},
					first_pinned, second_pinned, rest_length, stretch_cap));
			end
			if (out_valid && !out_stall) begin
				got.first = {new_first_z, new_first_y, new_first_x};
				got.second = {new_second_z, new_second_y, new_second_x};
				got.skip = skipped;
				if (expected_positions.size() == 0) begin
					if (mismatches < 10) begin
						$display("unexpected transaction: %h", got);
					end
					mismatches <= mismatches + 1;
				end else begin
					exp_p = expected_positions.pop_front();
					if (got !== exp_p) begin
						if (mismatches < 10) begin
							$display("mismatch: first exp %h got %h", exp_p.first, got.first);
							$display("  second exp %h got %h", exp_p.second, got.second);
							$display("  skipped exp %b got %b", exp_p.skip, got.skip);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (max_stretch_we) begin
				stretch_cap <= max_stretch_wdata;
			end
			pending <= expected_positions.size();
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: spring distance constraint unit
// Drives directed corner springs and random springs through several stretch
// settings with random gaps and output stalls, including one long stall,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
	import sdc_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    max_stretch_we = 1'b0;
	logic [StretchBits-1:0]  max_stretch_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [31:0]      first_x = '0, first_y = '0, first_z = '0;
	logic signed [31:0]      second_x = '0, second_y = '0, second_z = '0;
	logic                    first_pinned = 1'b0, second_pinned = 1'b0;
	logic [RestBits-1:0]     rest_length = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [31:0]      new_first_x, new_first_y, new_first_z;
	logic signed [31:0]      new_second_x, new_second_y, new_second_z;
	logic                    skipped;
	int                      mismatches, pending;
	bit                      no_gaps = 1'b0;
	logic                    long_hold = 1'b0;
	bit                      start_long_hold = 1'b0;
	int                      hold_left = 0;

	spring_distance_constraint_unit dut (.*);
	spring_projection_checker checker_i (.*);

	always #10 clk = ~clk;

	// receiver: random stall after each transaction, plus the long hold
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold_left = no_gaps ? 0 : $urandom_range(0, 3);
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= long_hold || (hold_left != 0);
	end

	// hold off the output for a long stretch while input keeps flowing
	initial begin
		wait (start_long_hold);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// offer one spring and wait for its acceptance
	task automatic send_spring(input logic [31:0] fx, fy, fz, sx, sy, sz,
		input logic p1, p2, input logic [30:0] rest);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_x <= fx; first_y <= fy; first_z <= fz;
		second_x <= sx; second_y <= sy; second_z <= sz;
		first_pinned <= p1; second_pinned <= p2;
		rest_length <= rest;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// write the stretch cap once the unit has drained
	task automatic set_stretch(input logic [StretchBits-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (80) @(posedge clk);
		max_stretch_wdata <= v;
		max_stretch_we <= 1'b1;
		@(posedge clk);
		max_stretch_we <= 1'b0;
	endtask

	task automatic random_spring();
		logic [31:0] f[3], s[3];
		logic [30:0] rest;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			f[i] = $urandom;
			case (kind)
				0, 1: s[i] = $urandom;
				2: s[i] = f[i] + $urandom_range(0, 6) - 3;
				3: begin
					f[i] = {f[i][31], {10{~f[i][31]}}, f[i][20:0]};
					s[i] = f[i] + {{8{f[i][0]}}, 24'($urandom)};
				end
				default: begin
					f[i] = {{12{f[i][31]}}, f[i][19:0]};
					s[i] = f[i] + {{14{f[i][1]}}, 18'($urandom)};
				end
			endcase
		end
		rest = (kind < 2 || kind == 3) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
		send_spring(f[0], f[1], f[2], s[0], s[1], s[2],
			($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0), rest);
	endtask

	initial begin
		logic [StretchBits-1:0] settings[6];
		settings = '{18'd65536, 18'd131072, 18'd72090, 18'd0, 18'h3ffff, 18'd98304};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner springs at the reset stretch cap
		send_spring(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_spring(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff);
		send_spring(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		send_spring(32'h10000, 0, 0, 32'h50000, 0, 0, 1, 1, 31'h10000);
		send_spring(32'h10000, 0, 0, 32'h50000, 0, 0, 1, 0, 31'h10000);
		send_spring(32'h10000, 0, 0, 32'h50000, 0, 0, 0, 1, 31'h10000);
		send_spring(32'h10000, 0, 0, 32'h50000, 0, 0, 0, 0, 31'h38000);
		send_spring(0, 0, 0, 6, 2, 1, 0, 0, 100);
		send_spring(0, 0, 0, 6, 2, 3, 0, 0, 100);
		send_spring(5, 5, 5, 5, 5, 5, 0, 0, 31'h7fffffff);
		send_spring(0, 0, 0, 32'h20000, 32'h30000, 32'hfffe0000, 0, 0, 31'h100000);
		send_spring(32'h7fff0000, 0, 0, 32'h80000000, 0, 0, 0, 0, 31'h7fffffff);
		send_spring(32'hffff0000, 32'h4000, 32'hfff00000,
			32'h30000, 32'hffffc000, 32'h100000, 0, 0, 31'h8000);
		send_spring(32'h7fffffff, 0, 0, 32'h7ffffff0, 0, 0, 1, 0, 31'h7fffffff);

		// random springs across stretch settings
		for (int ph = 0; ph < 6; ph++) begin
			set_stretch(settings[ph]);
			no_gaps = (ph == 2);
			for (int n = 0; n < 280; n++) begin
				if (ph == 1 && n == 40) begin
					start_long_hold = 1'b1;
				end
				random_spring();
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("[spring_distance_constraint_unit] OK");
		end else begin
			$display("[spring_distance_constraint_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#(20 * 500000);
		$display("[spring_distance_constraint_unit] ERROR");
		$finish;
	end

endmodule
